[sv/rc_stick_arm_disarm_detector_defines.svh]
// Assertion macros for the stick arm/disarm detector.
// Each macro names the clock and the active-low reset it is disabled by.
`ifndef RC_STICK_ARM_DISARM_DETECTOR_DEFINES_SVH
`define RC_STICK_ARM_DISARM_DETECTOR_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication: cons must hold whenever ante holds
`define RSAD_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
        else $error("rsad assertion failed");
// Next-cycle implication: cons must hold in the cycle after ante
`define RSAD_ASSERT_NEXT(label, clk_s, rst_s, ante, cons) \
    label: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
        else $error("rsad assertion failed");
`else
`define RSAD_ASSERT_IMPLY(label, clk_s, rst_s, ante, cons)
`define RSAD_ASSERT_NEXT(label, clk_s, rst_s, ante, cons)
`endif
`endif

[sv/rsad_pkg.sv]
package rsad_pkg;

    // Default sizing
    localparam int NUM_CHANNELS_DEF = 10;
    localparam int WIDTH_BITS_DEF   = 16;

    // Fixed field widths
    localparam int TIME_BITS      = 32;
    localparam int IN_CHANNELS    = 10;
    localparam int TARGET_BITS    = 7;
    localparam int MASK_BITS      = 10;
    localparam int STARTUP_BITS   = 7;
    localparam int STATUS_BITS    = 2;
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 10;
    localparam int OUT_TDATA_BITS = 8;
    localparam int NUM_STICKS     = 4;
    localparam int STICK_BITS     = 2;

    // Timing and scaling constants
    localparam int unsigned MIN_INTERVAL_MS = 20;
    localparam int unsigned STARTUP_MAX     = 100;
    localparam int unsigned STARTUP_CAL     = 90;
    localparam int unsigned UNLOCK_HOLD_MS  = 5000;
    localparam int unsigned LOCK_HOLD_MS    = 4000;
    localparam int unsigned PCT_FULL        = 100;
    localparam int unsigned MIN_RESET       = 1000;
    localparam int unsigned MAX_RESET       = 2000;

    // Register reset values
    localparam logic [MASK_BITS-1:0]   MASK_RESET       = 10'd1023;
    localparam logic [TARGET_BITS-1:0] YAW_TARGET_RESET = 7'd100;

    // Result status codes
    localparam logic [STATUS_BITS-1:0] STATUS_BUSY     = 2'd0;
    localparam logic [STATUS_BITS-1:0] STATUS_LOCKED   = 2'd1;
    localparam logic [STATUS_BITS-1:0] STATUS_UNLOCKED = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CAL_ENABLE      = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_CHANNEL_MASK    = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNLOCK_ROLL     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNLOCK_PITCH    = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNLOCK_YAW      = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNLOCK_THROTTLE = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_LOCK_THROTTLE   = 3'd6;

    // Stick indexes
    localparam logic [STICK_BITS-1:0] ROLL_STICK     = 2'd0;
    localparam logic [STICK_BITS-1:0] THROTTLE_STICK = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_UPDATE,
        ST_PREP,
        ST_MUL,
        ST_CMP,
        ST_FINISH,
        ST_HOLD
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic                  accept;
        logic                  eval;
        logic                  update;
        logic                  prep;
        logic                  mul;
        logic                  cmp;
        logic                  finish;
        logic                  out_load;
        logic [STICK_BITS-1:0] sel;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic busy;
        logic locked;
    } status_t;

    // Saturating add of millisecond sums
    function automatic logic [TIME_BITS-1:0] sat_add(input logic [TIME_BITS-1:0] a,
                                                     input logic [TIME_BITS-1:0] b);
        logic [TIME_BITS:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TIME_BITS] ? {TIME_BITS{1'b1}} : s[TIME_BITS-1:0];
    endfunction

endpackage

[sv/rsad_out_reg.sv]
module rsad_out_reg
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 load,
    input  logic [rsad_pkg::STATUS_BITS-1:0]     res_status,
    input  logic                                 res_healthy,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [rsad_pkg::OUT_TDATA_BITS-1:0]  m_tdata
);

    localparam int PAD_BITS = rsad_pkg::OUT_TDATA_BITS - rsad_pkg::STATUS_BITS - 1;

    logic                             valid_reg;
    logic                             valid_next;
    logic [rsad_pkg::STATUS_BITS-1:0] status_reg;
    logic                             healthy_reg;

    // Set on load, drop once the item is taken
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Hold the result payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            status_reg  <= res_status;
            healthy_reg <= res_healthy;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {{PAD_BITS{1'b0}}, healthy_reg, status_reg};

endmodule

[sv/rsad_ctrl.sv]
`include "rc_stick_arm_disarm_detector_defines.svh"

module rsad_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic              out_free,
    input  rsad_pkg::status_t status,
    output rsad_pkg::cmd_t    cmd
);

    rsad_pkg::state_t                  state_reg;
    rsad_pkg::state_t                  state_next;
    logic [rsad_pkg::STICK_BITS-1:0]   idx_reg;
    logic [rsad_pkg::STICK_BITS-1:0]   idx_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= rsad_pkg::ST_IDLE;
            idx_reg   <= rsad_pkg::ROLL_STICK;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Sequence one item: interval check, state update, stick checks, dwell
    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        cmd.sel    = idx_reg;
        case (state_reg)
            rsad_pkg::ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = rsad_pkg::ST_EVAL;
                end
            end
            rsad_pkg::ST_EVAL:
            begin
                cmd.eval = 1'b1;
                if (status.busy)
                begin
                    state_next = rsad_pkg::ST_HOLD;
                end
                else
                begin
                    state_next = rsad_pkg::ST_UPDATE;
                end
            end
            rsad_pkg::ST_UPDATE:
            begin
                cmd.update = 1'b1;
                // Unlocked blocks only look at the throttle
                idx_next   = status.locked ? rsad_pkg::ROLL_STICK : rsad_pkg::THROTTLE_STICK;
                state_next = rsad_pkg::ST_PREP;
            end
            rsad_pkg::ST_PREP:
            begin
                cmd.prep   = 1'b1;
                state_next = rsad_pkg::ST_MUL;
            end
            rsad_pkg::ST_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = rsad_pkg::ST_CMP;
            end
            rsad_pkg::ST_CMP:
            begin
                cmd.cmp = 1'b1;
                if (idx_reg == rsad_pkg::THROTTLE_STICK)
                begin
                    state_next = rsad_pkg::ST_FINISH;
                end
                else
                begin
                    idx_next   = idx_reg + rsad_pkg::STICK_BITS'(1);
                    state_next = rsad_pkg::ST_PREP;
                end
            end
            rsad_pkg::ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = rsad_pkg::ST_HOLD;
            end
            rsad_pkg::ST_HOLD:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = rsad_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = rsad_pkg::ST_IDLE;
            end
        endcase
    end

    // A busy item skips the state update and the stick checks
    `RSAD_ASSERT_NEXT(a_busy_skips, clk, rst_n,
                      state_reg == rsad_pkg::ST_EVAL && status.busy,
                      state_reg == rsad_pkg::ST_HOLD)
    // An unlocked block checks the throttle alone
    `RSAD_ASSERT_NEXT(a_unlocked_throttle, clk, rst_n,
                      state_reg == rsad_pkg::ST_UPDATE && !status.locked,
                      idx_reg == rsad_pkg::THROTTLE_STICK)
    // One item at a time
    `RSAD_ASSERT_NEXT(a_one_item, clk, rst_n, in_valid && in_ready, !in_ready)

endmodule

[sv/rsad_datapath.sv]
`include "rc_stick_arm_disarm_detector_defines.svh"

module rsad_datapath
#(
    parameter  int NUM_CHANNELS  = rsad_pkg::NUM_CHANNELS_DEF,
    parameter  int WIDTH_BITS    = rsad_pkg::WIDTH_BITS_DEF,
    localparam int IN_BITS       = rsad_pkg::TIME_BITS + rsad_pkg::IN_CHANNELS * WIDTH_BITS,
    localparam int IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  rsad_pkg::cmd_t                        cmd,
    output rsad_pkg::status_t                     status,
    input  logic                                  cfg_we,
    input  logic [rsad_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [rsad_pkg::CFG_DATA_BITS-1:0]    cfg_data,
    input  logic [IN_TDATA_BITS-1:0]              in_data,
    output logic [rsad_pkg::STATUS_BITS-1:0]      res_status,
    output logic                                  res_healthy
);

    localparam int CAL_CHANNELS = (NUM_CHANNELS < rsad_pkg::IN_CHANNELS) ?
                                  NUM_CHANNELS : rsad_pkg::IN_CHANNELS;
    localparam int PROD_BITS    = WIDTH_BITS + rsad_pkg::TARGET_BITS;
    localparam int TB           = rsad_pkg::TIME_BITS;
    localparam int SB           = rsad_pkg::STARTUP_BITS;
    localparam logic [WIDTH_BITS-1:0] MIN_INIT = WIDTH_BITS'(rsad_pkg::MIN_RESET);
    localparam logic [WIDTH_BITS-1:0] MAX_INIT = WIDTH_BITS'(rsad_pkg::MAX_RESET);

    // Configuration registers
    logic                                cal_en_reg;
    logic [rsad_pkg::MASK_BITS-1:0]      mask_reg;
    logic [rsad_pkg::TARGET_BITS-1:0]    unlock_target_reg [rsad_pkg::NUM_STICKS];
    logic [rsad_pkg::TARGET_BITS-1:0]    lock_target_reg;

    // Input item
    logic [TB-1:0]                       time_reg;
    logic [WIDTH_BITS-1:0]               width_reg [rsad_pkg::IN_CHANNELS];

    // Block state
    logic [TB-1:0]                       last_time_reg;
    logic [TB-1:0]                       interval_reg;
    logic [SB-1:0]                       startup_reg;
    logic [SB-1:0]                       startup_next;
    logic [WIDTH_BITS-1:0]               min_reg [CAL_CHANNELS];
    logic [WIDTH_BITS-1:0]               max_reg [CAL_CHANNELS];
    logic [WIDTH_BITS-1:0]               raw_reg [rsad_pkg::NUM_STICKS];
    logic                                locked_reg;
    logic [TB-1:0]                       unlock_dwell_reg;
    logic [TB-1:0]                       lock_dwell_reg;
    logic                                health_flag_reg;
    logic                                near_all_reg;
    logic [rsad_pkg::STATUS_BITS-1:0]    res_status_reg;
    logic                                res_healthy_reg;

    // Stick check pipeline
    logic [WIDTH_BITS-1:0]               d_reg;
    logic [WIDTH_BITS-1:0]               n_reg;
    logic [rsad_pkg::TARGET_BITS-1:0]    t_reg;
    logic                                degen_reg;
    logic [PROD_BITS-1:0]                p1_reg;
    logic [PROD_BITS-1:0]                p2_reg;

    logic [TB-1:0]                       interval_w;
    logic                                cal_on;
    logic [WIDTH_BITS-1:0]               stick_min [rsad_pkg::NUM_STICKS];
    logic [WIDTH_BITS-1:0]               stick_max [rsad_pkg::NUM_STICKS];
    logic [rsad_pkg::NUM_STICKS-1:0]     stick_mask;
    logic [WIDTH_BITS-1:0]               sel_min;
    logic [WIDTH_BITS-1:0]               sel_max;
    logic [WIDTH_BITS-1:0]               sel_raw;
    logic [WIDTH_BITS-1:0]               span_w;
    logic [WIDTH_BITS-1:0]               off_w;
    logic [rsad_pkg::TARGET_BITS-1:0]    sel_t;
    logic                                degen_w;
    logic [PROD_BITS-1:0]                abs_w;
    logic                                near_w;
    logic [TB-1:0]                       ud_next;
    logic [TB-1:0]                       ld_next;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_en_reg           <= 1'b0;
            mask_reg             <= rsad_pkg::MASK_RESET;
            unlock_target_reg[0] <= '0;
            unlock_target_reg[1] <= '0;
            unlock_target_reg[2] <= rsad_pkg::YAW_TARGET_RESET;
            unlock_target_reg[3] <= '0;
            lock_target_reg      <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rsad_pkg::CFG_CAL_ENABLE:
                    cal_en_reg <= cfg_data[0];
                rsad_pkg::CFG_CHANNEL_MASK:
                    mask_reg <= cfg_data[rsad_pkg::MASK_BITS-1:0];
                rsad_pkg::CFG_UNLOCK_ROLL:
                    unlock_target_reg[0] <= cfg_data[rsad_pkg::TARGET_BITS-1:0];
                rsad_pkg::CFG_UNLOCK_PITCH:
                    unlock_target_reg[1] <= cfg_data[rsad_pkg::TARGET_BITS-1:0];
                rsad_pkg::CFG_UNLOCK_YAW:
                    unlock_target_reg[2] <= cfg_data[rsad_pkg::TARGET_BITS-1:0];
                rsad_pkg::CFG_UNLOCK_THROTTLE:
                    unlock_target_reg[3] <= cfg_data[rsad_pkg::TARGET_BITS-1:0];
                rsad_pkg::CFG_LOCK_THROTTLE:
                    lock_target_reg <= cfg_data[rsad_pkg::TARGET_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Capture the input item
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            time_reg <= in_data[TB-1:0];
            for (int i = 0; i < rsad_pkg::IN_CHANNELS; i++)
            begin
                width_reg[i] <= in_data[TB + i * WIDTH_BITS +: WIDTH_BITS];
            end
        end
    end

    // Interval since the last non-busy item, wrapping
    assign interval_w    = time_reg - last_time_reg;
    assign status.busy   = interval_w < TB'(rsad_pkg::MIN_INTERVAL_MS);
    assign status.locked = locked_reg;

    // Saturating startup count and calibration gate
    assign startup_next = (startup_reg < SB'(rsad_pkg::STARTUP_MAX)) ?
                          startup_reg + SB'(1) : startup_reg;
    assign cal_on       = locked_reg && cal_en_reg &&
                          (startup_next > SB'(rsad_pkg::STARTUP_CAL));

    // Learn min and max per enabled channel
    for (genvar ch = 0; ch < CAL_CHANNELS; ch++)
    begin : g_cal
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                min_reg[ch] <= MIN_INIT;
                max_reg[ch] <= MAX_INIT;
            end
            else if (cmd.update && mask_reg[ch] && cal_on)
            begin
                if (width_reg[ch] > max_reg[ch])
                begin
                    max_reg[ch] <= width_reg[ch];
                end
                if (width_reg[ch] < min_reg[ch])
                begin
                    min_reg[ch] <= width_reg[ch];
                end
            end
        end
    end

    // Keep the last raw width of each enabled stick
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < rsad_pkg::NUM_STICKS; k++)
            begin
                raw_reg[k] <= '0;
            end
        end
        else if (cmd.update)
        begin
            for (int k = 0; k < rsad_pkg::NUM_STICKS; k++)
            begin
                if (mask_reg[k])
                begin
                    raw_reg[k] <= width_reg[k];
                end
            end
        end
    end

    // Stick views of the calibration registers
    always_comb
    begin
        for (int k = 0; k < rsad_pkg::NUM_STICKS; k++)
        begin
            stick_min[k]  = min_reg[k];
            stick_max[k]  = max_reg[k];
            stick_mask[k] = mask_reg[k];
        end
    end

    // Select one stick, clamp its offset into the span
    always_comb
    begin
        sel_min = stick_min[cmd.sel];
        sel_max = stick_max[cmd.sel];
        sel_raw = raw_reg[cmd.sel];
        sel_t   = locked_reg ? unlock_target_reg[cmd.sel] : lock_target_reg;
        span_w  = sel_max - sel_min;
        degen_w = !stick_mask[cmd.sel] || (sel_max <= sel_min);
        if (sel_raw <= sel_min)
        begin
            off_w = '0;
        end
        else if (sel_raw >= sel_max)
        begin
            off_w = span_w;
        end
        else
        begin
            off_w = sel_raw - sel_min;
        end
    end

    // Register the operands, then the cross products
    always_ff @(posedge clk)
    begin
        if (cmd.prep)
        begin
            d_reg     <= span_w;
            n_reg     <= off_w;
            t_reg     <= sel_t;
            degen_reg <= degen_w;
        end
        if (cmd.mul)
        begin
            p1_reg <= PROD_BITS'(n_reg) * PROD_BITS'(rsad_pkg::PCT_FULL);
            p2_reg <= PROD_BITS'(t_reg) * PROD_BITS'(d_reg);
        end
    end

    // |100*n - t*d| < d, or a dead channel matches only a zero target
    always_comb
    begin
        abs_w  = (p1_reg >= p2_reg) ? (p1_reg - p2_reg) : (p2_reg - p1_reg);
        near_w = degen_reg ? (t_reg == '0) : (abs_w < PROD_BITS'(d_reg));
    end

    // Dwell sums for this item
    assign ud_next = (!cal_en_reg && near_all_reg) ?
                     rsad_pkg::sat_add(unlock_dwell_reg, interval_reg) : '0;
    assign ld_next = near_all_reg ?
                     rsad_pkg::sat_add(lock_dwell_reg, interval_reg) : '0;

    // Advance block state and build the result
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_time_reg    <= '0;
            interval_reg     <= '0;
            startup_reg      <= '0;
            locked_reg       <= 1'b1;
            unlock_dwell_reg <= '0;
            lock_dwell_reg   <= '0;
            health_flag_reg  <= 1'b0;
            near_all_reg     <= 1'b0;
            res_status_reg   <= rsad_pkg::STATUS_BUSY;
            res_healthy_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.eval)
            begin
                interval_reg <= interval_w;
                if (status.busy)
                begin
                    res_status_reg  <= rsad_pkg::STATUS_BUSY;
                    res_healthy_reg <= health_flag_reg;
                end
            end
            if (cmd.update)
            begin
                last_time_reg   <= time_reg;
                startup_reg     <= startup_next;
                health_flag_reg <= 1'b1;
                near_all_reg    <= 1'b1;
            end
            if (cmd.cmp)
            begin
                near_all_reg <= near_all_reg && near_w;
            end
            if (cmd.finish)
            begin
                res_healthy_reg <= 1'b1;
                if (locked_reg)
                begin
                    unlock_dwell_reg <= ud_next;
                    lock_dwell_reg   <= '0;
                    res_status_reg   <= rsad_pkg::STATUS_LOCKED;
                    if (ud_next > TB'(rsad_pkg::UNLOCK_HOLD_MS))
                    begin
                        locked_reg <= 1'b0;
                    end
                end
                else
                begin
                    lock_dwell_reg   <= ld_next;
                    unlock_dwell_reg <= '0;
                    res_status_reg   <= rsad_pkg::STATUS_UNLOCKED;
                    if (ld_next > TB'(rsad_pkg::LOCK_HOLD_MS))
                    begin
                        locked_reg <= 1'b1;
                    end
                end
            end
        end
    end

    assign res_status  = res_status_reg;
    assign res_healthy = res_healthy_reg;

    // Lock state moves only at the dwell step
    `RSAD_ASSERT_NEXT(a_lock_at_finish, clk, rst_n, !cmd.finish, $stable(locked_reg))
    // Last time moves only on an accepted, non-busy item
    `RSAD_ASSERT_NEXT(a_time_at_update, clk, rst_n, !cmd.update, $stable(last_time_reg))
    // Health, once set, stays set
    `RSAD_ASSERT_NEXT(a_health_sticks, clk, rst_n, health_flag_reg, health_flag_reg)

endmodule

[sv/rc_stick_arm_disarm_detector.sv]
// Channel  Dir  Handshake            Payload
// s_*      in   s_tvalid/s_tready    s_tdata: time_ms, width_ch1 .. width_ch10
// m_*      out  m_tvalid/m_tready    m_tdata: status, healthy
// cfg_*    in   cfg_we               cfg_index, cfg_data
//
// One item at a time; each item gives exactly one result.
// A busy item skips the stick checks and an unlocked block checks the throttle
// alone; each stick check is three passes (clamp, multiply, compare) through
// one shared cross-multiply unit, and a locked block checks all four sticks.
// The result sits in an output register, so a new item is taken while it waits.
// Reset (rst_n, async, active low) clears control and block state to locked, uncalibrated.
module rc_stick_arm_disarm_detector
#(
    parameter  int NUM_CHANNELS  = rsad_pkg::NUM_CHANNELS_DEF,
    parameter  int WIDTH_BITS    = rsad_pkg::WIDTH_BITS_DEF,
    localparam int IN_BITS       = rsad_pkg::TIME_BITS + rsad_pkg::IN_CHANNELS * WIDTH_BITS,
    localparam int IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8
)
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // time_ms, width_ch1 .. width_ch10 from bit 0 up, zero fill
    input  logic [IN_TDATA_BITS-1:0]             s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // status [1:0], healthy [2], zero fill
    output logic [rsad_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
    input  logic                                 cfg_we,
    input  logic [rsad_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [rsad_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    rsad_pkg::cmd_t                     cmd;
    rsad_pkg::status_t                  status;
    logic [rsad_pkg::STATUS_BITS-1:0]   res_status;
    logic                               res_healthy;
    logic                               out_free;

    assign out_free = !m_tvalid || m_tready;

    rsad_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .out_free (out_free),
        .status   (status),
        .cmd      (cmd)
    );

    rsad_datapath
    #(
        .NUM_CHANNELS (NUM_CHANNELS),
        .WIDTH_BITS   (WIDTH_BITS)
    )
    u_datapath
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .status      (status),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_data     (s_tdata),
        .res_status  (res_status),
        .res_healthy (res_healthy)
    );

    rsad_out_reg u_out_reg
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (cmd.out_load),
        .res_status  (res_status),
        .res_healthy (res_healthy),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

endmodule
